@@ hw/rtl/xcbc_pkg.sv @@
// ----------------------------------------------------------------------------
// xcbc_pkg
// Types and constants shared by the chained XTEA block cipher.
// ----------------------------------------------------------------------------
package xcbc_pkg;

    localparam int WordW   = 32;
    localparam int BlockW  = 64;
    localparam int RoundsW = 7;
    localparam int IndexW  = 3;

    localparam logic [WordW-1:0]   Delta       = 32'h9e3779b9;
    localparam logic [RoundsW-1:0] RoundsReset = 7'd32;

    // register indexes of the configuration port
    localparam logic [IndexW-1:0] RegKey0  = 3'd0;
    localparam logic [IndexW-1:0] RegKey1  = 3'd1;
    localparam logic [IndexW-1:0] RegKey2  = 3'd2;
    localparam logic [IndexW-1:0] RegKey3  = 3'd3;
    localparam logic [IndexW-1:0] RegRounds = 3'd4;
    localparam logic [IndexW-1:0] RegDir   = 3'd5;

    typedef logic [WordW-1:0]        word_t;
    typedef logic [BlockW-1:0]       block_t;
    typedef logic [3:0][WordW-1:0]   key_t;

    typedef struct packed {
        logic               start;
        logic               dec;
        logic [RoundsW-1:0] rounds;
    } core_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

endpackage

@@ hw/rtl/xcbc_if.sv @@
// ----------------------------------------------------------------------------
// xcbc_if
// Valid/ready channels for input blocks and result blocks.
// ----------------------------------------------------------------------------
interface xcbc_in_if;
    logic               valid;
    logic               ready;
    xcbc_pkg::word_t    block_lo;
    xcbc_pkg::word_t    block_hi;
    logic               first_block;

    modport source (output valid, output block_lo, output block_hi, output first_block,
                    input ready);
    modport sink   (input valid, input block_lo, input block_hi, input first_block,
                    output ready);
endinterface

interface xcbc_out_if;
    logic               valid;
    logic               ready;
    xcbc_pkg::word_t    out_lo;
    xcbc_pkg::word_t    out_hi;

    modport source (output valid, output out_lo, output out_hi, input ready);
    modport sink   (input valid, input out_lo, input out_hi, output ready);
endinterface

@@ hw/rtl/xcbc_round.sv @@
// ----------------------------------------------------------------------------
// xcbc_round
// One XTEA half-round: target word plus or minus the mix of the source word.
// ----------------------------------------------------------------------------
module xcbc_round (
    input  xcbc_pkg::word_t src,
    input  xcbc_pkg::word_t acc,
    input  xcbc_pkg::word_t sum,
    input  xcbc_pkg::word_t key,
    input  logic            sub,
    output xcbc_pkg::word_t res
);

    xcbc_pkg::word_t mix;

    assign mix = ((src << 4) ^ (src >> 5)) + (src ^ sum) + key;
    assign res = sub ? (acc - mix) : (acc + mix);

endmodule

@@ hw/rtl/xcbc_core.sv @@
// ----------------------------------------------------------------------------
// xcbc_core
// Iterative XTEA core: one half-round per clock through a shared round unit.
// ----------------------------------------------------------------------------
module xcbc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  xcbc_pkg::core_ctl_t  ctl,
    input  xcbc_pkg::key_t       key,
    input  xcbc_pkg::block_t     blk,
    output xcbc_pkg::core_stat_t stat,
    output xcbc_pkg::block_t     result
);

    localparam int RemW = xcbc_pkg::RoundsW + 1;
    localparam int ProdW = xcbc_pkg::WordW + xcbc_pkg::RoundsW;

    xcbc_pkg::word_t y_reg;
    xcbc_pkg::word_t z_reg;
    xcbc_pkg::word_t sum_reg;
    logic [RemW-1:0] rem_reg;
    logic            phase_reg;
    logic            dec_reg;
    logic            busy_reg;
    logic            done_reg;

    logic             to_z;
    logic [1:0]       key_idx;
    xcbc_pkg::word_t  src;
    xcbc_pkg::word_t  acc;
    xcbc_pkg::word_t  acc_next;
    logic [ProdW-1:0] sum_prod;
    xcbc_pkg::word_t  sum_init;

    // the half-round that writes z reads y, and takes its key from sum bits 12:11
    assign to_z    = phase_reg ^ dec_reg;
    assign key_idx = to_z ? sum_reg[12:11] : sum_reg[1:0];
    assign src     = to_z ? y_reg : z_reg;
    assign acc     = to_z ? z_reg : y_reg;

    // decryption starts from delta times the round count
    assign sum_prod = {{xcbc_pkg::RoundsW{1'b0}}, xcbc_pkg::Delta}
                    * {{xcbc_pkg::WordW{1'b0}}, ctl.rounds};
    assign sum_init = sum_prod[xcbc_pkg::WordW-1:0];

    xcbc_round u_round (
        .src (src),
        .acc (acc),
        .sum (sum_reg),
        .key (key[key_idx]),
        .sub (dec_reg),
        .res (acc_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            phase_reg <= 1'b0;
            dec_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (ctl.start)
        begin
            rem_reg   <= {ctl.rounds, 1'b0};
            phase_reg <= 1'b0;
            dec_reg   <= ctl.dec;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (rem_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                rem_reg   <= rem_reg - RemW'(1);
                phase_reg <= ~phase_reg;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            y_reg   <= blk[xcbc_pkg::WordW-1:0];
            z_reg   <= blk[xcbc_pkg::BlockW-1:xcbc_pkg::WordW];
            sum_reg <= ctl.dec ? sum_init : '0;
        end
        else if (busy_reg && (rem_reg != '0))
        begin
            if (to_z)
            begin
                z_reg <= acc_next;
            end
            else
            begin
                y_reg <= acc_next;
            end
            // sum steps between the two halves of a cycle
            if (!phase_reg)
            begin
                sum_reg <= dec_reg ? (sum_reg - xcbc_pkg::Delta) : (sum_reg + xcbc_pkg::Delta);
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = {z_reg, y_reg};

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("core done without a preceding run");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !busy_reg)
        else $error("core started while running");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (rem_reg != '0) && !ctl.start) |=> (rem_reg == $past(rem_reg) - RemW'(1)))
        else $error("half-round counter skipped");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && !ctl.start) |=> ($stable(y_reg) && $stable(z_reg)))
        else $error("core result changed while idle");

endmodule

@@ hw/rtl/xtea_chained_block_crypt.sv @@
// ----------------------------------------------------------------------------
// xtea_chained_block_crypt
// XTEA with configurable rounds and two-way block chaining on 64-bit blocks.
//
//   channel   dir  payload                           transfer
//   blocks    in   block_lo, block_hi, first_block   valid & ready
//   results   out  out_lo, out_hi                    valid & ready
//   wr_*      in   wr_index, wr_data                 wr_en
//
// the core does one half-round per clock through its single round unit
// ready is low while a block is in the core or its result waits for a free
// output register; the output register lets a result wait while the next
// block enters
// reset: keys zero, 32 rounds, encrypt, chain state zero
// ----------------------------------------------------------------------------
module xtea_chained_block_crypt (
    input  logic                          clk,
    input  logic                          rst_n,
    xcbc_in_if.sink                       blocks,
    xcbc_out_if.source                    results,
    input  logic                          wr_en,
    input  logic [xcbc_pkg::IndexW-1:0]   wr_index,
    input  xcbc_pkg::word_t               wr_data
);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StRun  = 2'd1;
    localparam logic [1:0] StHold = 2'd2;

    logic [1:0]                   state_reg;
    xcbc_pkg::key_t               key_reg;
    logic [xcbc_pkg::RoundsW-1:0] rounds_reg;
    logic                         dir_reg;
    xcbc_pkg::block_t             prev_cipher_reg;
    xcbc_pkg::block_t             prev_plain_reg;
    xcbc_pkg::block_t             blk_reg;
    logic                         first_reg;
    logic                         dec_reg;
    logic                         out_valid_reg;
    xcbc_pkg::word_t              out_lo_reg;
    xcbc_pkg::word_t              out_hi_reg;

    xcbc_pkg::core_ctl_t  core_ctl;
    xcbc_pkg::core_stat_t core_stat;
    xcbc_pkg::block_t     core_result;
    xcbc_pkg::block_t     in_blk;
    xcbc_pkg::block_t     chain_in;
    xcbc_pkg::block_t     chain_out;
    xcbc_pkg::block_t     res;
    logic                 in_xfer;
    logic                 finish;
    logic                 load;

    assign blocks.ready = (state_reg == StIdle);
    assign in_xfer      = blocks.valid && blocks.ready;

    assign in_blk   = {blocks.block_hi, blocks.block_lo};
    assign chain_in = blocks.first_block ? '0 : (dir_reg ? prev_plain_reg : prev_cipher_reg);

    assign core_ctl.start  = in_xfer;
    assign core_ctl.dec    = dir_reg;
    assign core_ctl.rounds = rounds_reg;

    xcbc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (core_ctl),
        .key    (key_reg),
        .blk    (in_blk ^ chain_in),
        .stat   (core_stat),
        .result (core_result)
    );

    assign chain_out = first_reg ? '0 : (dec_reg ? prev_cipher_reg : prev_plain_reg);
    assign res       = core_result ^ chain_out;

    assign finish = ((state_reg == StRun) && core_stat.done) || (state_reg == StHold);
    assign load   = finish && (!out_valid_reg || results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            rounds_reg <= xcbc_pkg::RoundsReset;
            dir_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                xcbc_pkg::RegKey0:   key_reg[0] <= wr_data;
                xcbc_pkg::RegKey1:   key_reg[1] <= wr_data;
                xcbc_pkg::RegKey2:   key_reg[2] <= wr_data;
                xcbc_pkg::RegKey3:   key_reg[3] <= wr_data;
                xcbc_pkg::RegRounds: rounds_reg <= wr_data[xcbc_pkg::RoundsW-1:0];
                xcbc_pkg::RegDir:    dir_reg    <= wr_data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= StIdle;
            out_valid_reg   <= 1'b0;
            prev_cipher_reg <= '0;
            prev_plain_reg  <= '0;
            first_reg       <= 1'b0;
            dec_reg         <= 1'b0;
        end
        else
        begin
            case (state_reg)
                StIdle:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= StRun;
                        first_reg <= blocks.first_block;
                        dec_reg   <= dir_reg;
                    end
                end
                StRun:
                begin
                    if (load)
                    begin
                        state_reg <= StIdle;
                    end
                    else if (core_stat.done)
                    begin
                        state_reg <= StHold;
                    end
                end
                StHold:
                begin
                    if (load)
                    begin
                        state_reg <= StIdle;
                    end
                end
                default:
                begin
                    state_reg <= StIdle;
                end
            endcase

            if (load)
            begin
                out_valid_reg <= 1'b1;
                // chain state keeps the input block before chaining and the result after chaining
                if (dec_reg)
                begin
                    prev_cipher_reg <= blk_reg;
                    prev_plain_reg  <= res;
                end
                else
                begin
                    prev_plain_reg  <= blk_reg;
                    prev_cipher_reg <= res;
                end
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            blk_reg <= in_blk;
        end
        if (load)
        begin
            out_lo_reg <= res[xcbc_pkg::WordW-1:0];
            out_hi_reg <= res[xcbc_pkg::BlockW-1:xcbc_pkg::WordW];
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.out_lo = out_lo_reg;
    assign results.out_hi = out_hi_reg;

endmodule
